FILE: hw/rtl/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_PIN    = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_ACCEPT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_VALID  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STALE      = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RPM_LIMIT  = 2'd3;

   localparam logic [CSR_DATA_BITS-1:0] RST_MIN_ACCEPT = 16'd10;
   localparam logic [CSR_DATA_BITS-1:0] RST_MIN_VALID  = 16'd6;
   localparam logic [CSR_DATA_BITS-1:0] RST_STALE      = 16'd2000;
   localparam logic [CSR_DATA_BITS-1:0] RST_RPM_LIMIT  = 16'd9999;

   // quotient of 60000 / period never exceeds 16 bits
   localparam int QUOT_BITS = 16;
   localparam logic [QUOT_BITS-1:0] MS_PER_MINUTE = 16'd60000;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tpm_if.sv
`default_nettype none

interface tpm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic               pin_level;
   logic signed [31:0] motor_position;

   modport source (output valid, output cmd, output pin_level, output motor_position,
                   input ready);
   modport sink (input valid, input cmd, input pin_level, input motor_position,
                 output ready);
endinterface

interface tpm_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        rpm;
   logic [31:0]        pulse_total;
   logic [31:0]        period_now;
   logic signed [31:0] latched_position;
   logic               latch_valid;

   modport source (output valid, output rpm, output pulse_total, output period_now,
                   output latched_position, output latch_valid, input ready);
   modport sink (input valid, input rpm, input pulse_total, input period_now,
                 input latched_position, input latch_valid, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tpm_div.sv
`default_nettype none

module tpm_div
   import tpm_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [TIME_BITS-1:0] divisor,
   output div_stat_type              stat
);

   localparam int CW       = TIME_BITS + 1;
   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [QUOT_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quo_ff, quo_in;

   logic [QUOT_BITS:0]   trial;
   logic [CW-1:0]        trial_ext;
   logic [CW-1:0]        div_ext;
   logic [CW-1:0]        diff;
   logic                 fits;

   // restoring division, one quotient bit per cycle; dividend bits shift
   // out of the top of quo_ff while quotient bits shift in at the bottom
   always_comb begin
      trial     = {rem_ff, quo_ff[QUOT_BITS-1]};
      trial_ext = CW'(trial);
      div_ext   = CW'(divisor);
      fits      = trial_ext >= div_ext;
      diff      = trial_ext - div_ext;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QUOT_BITS);
         rem_in  = '0;
         quo_in  = MS_PER_MINUTE;
      end else if (busy_ff) begin
         rem_in = fits ? diff[QUOT_BITS-1:0] : trial[QUOT_BITS-1:0];
         quo_in = {quo_ff[QUOT_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tacho_period_rpm_meter.sv
`default_nettype none

// Tachometer meter: tick requests advance a millisecond counter, pin-change
// requests capture the motor position (once per clear) and, on a falling
// level, count a pulse and measure the period since the previous low edge.
// Every request returns one response with rpm = min(limit, 60000 / period),
// forced to zero for a short or stale period. Each request passes through
// the state update, the serial divider (one quotient bit per cycle over 16
// bits), saturation and the response register load, which waits while an
// older response is untaken; then the block is ready again. The response
// register lets the block take the next request while a response waits.
module tacho_period_rpm_meter
   import tpm_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tpm_req_if.sink                       req_ch,
   tpm_rsp_if.source                     rsp_ch,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_DATA_BITS-1:0] min_accept_ff, min_valid_ff, stale_ff, rpm_limit_ff;

   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] last_low_ff, last_low_in;
   logic                 have_low_ff, have_low_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [31:0]          pulse_ff, pulse_in;
   logic signed [31:0]   pos_latch_ff, pos_latch_in;
   logic                 latch_full_ff, latch_full_in;

   logic                 div_start_ff;
   logic                 zero_ff, zero_in;
   logic [15:0]          rpm_ff, rpm_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_rpm_ff;
   logic [31:0]          rsp_pulse_ff;
   logic [31:0]          rsp_period_ff;
   logic signed [31:0]   rsp_pos_ff;
   logic                 rsp_latch_ff;

   logic                 accept;
   logic                 rsp_load;
   logic [TIME_BITS-1:0] elapsed;
   div_stat_type         div_stat;

   tpm_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .divisor (period_ff),
      .stat    (div_stat)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign elapsed      = time_ff - last_low_ff;
   assign rsp_load     = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_accept_ff <= RST_MIN_ACCEPT;
         min_valid_ff  <= RST_MIN_VALID;
         stale_ff      <= RST_STALE;
         rpm_limit_ff  <= RST_RPM_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_ACCEPT: min_accept_ff <= csr_wdata;
            CSR_MIN_VALID:  min_valid_ff  <= csr_wdata;
            CSR_STALE:      stale_ff      <= csr_wdata;
            CSR_RPM_LIMIT:  rpm_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request update
   always_comb begin
      time_in       = time_ff;
      last_low_in   = last_low_ff;
      have_low_in   = have_low_ff;
      period_in     = period_ff;
      pulse_in      = pulse_ff;
      pos_latch_in  = pos_latch_ff;
      latch_full_in = latch_full_ff;

      if (accept) begin
         unique case (cmd_type'(req_ch.cmd))
            CMD_TICK: time_in = time_ff + 1'b1;
            CMD_PIN: begin
               if (!latch_full_ff) begin
                  pos_latch_in  = req_ch.motor_position;
                  latch_full_in = 1'b1;
               end
               if (!req_ch.pin_level) begin
                  pulse_in = pulse_ff + 1'b1;
                  if (have_low_ff && (elapsed >= TIME_BITS'(min_accept_ff))) begin
                     period_in = elapsed;
                  end
                  last_low_in = time_ff;
                  have_low_in = 1'b1;
               end
            end
            CMD_CLEAR:  latch_full_in = 1'b0;
            CMD_STATUS: ;
            default: ;
         endcase
      end
   end

   // sequencing and rpm
   always_comb begin
      state_in = state_ff;
      zero_in  = zero_ff;
      rpm_in   = rpm_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            zero_in = (period_ff == '0) ||
                      (period_ff < TIME_BITS'(min_valid_ff)) ||
                      (elapsed > TIME_BITS'(stale_ff));
            if (div_stat.done) begin
               state_in = ST_HOLD;
               if (zero_ff) begin
                  rpm_in = '0;
               end else if (div_stat.quotient > rpm_limit_ff) begin
                  rpm_in = rpm_limit_ff;
               end else begin
                  rpm_in = div_stat.quotient;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_ff       <= '0;
         last_low_ff   <= '0;
         have_low_ff   <= 1'b0;
         period_ff     <= '0;
         pulse_ff      <= '0;
         pos_latch_ff  <= '0;
         latch_full_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_ff       <= time_in;
         last_low_ff   <= last_low_in;
         have_low_ff   <= have_low_in;
         period_ff     <= period_in;
         pulse_ff      <= pulse_in;
         pos_latch_ff  <= pos_latch_in;
         latch_full_ff <= latch_full_in;
         div_start_ff  <= accept;
         rsp_valid_ff  <= rsp_valid_in;
      end
      zero_ff <= zero_in;
      rpm_ff  <= rpm_in;
      if (rsp_load) begin
         rsp_rpm_ff    <= rpm_ff;
         rsp_pulse_ff  <= pulse_ff;
         rsp_period_ff <= 32'(period_ff);
         rsp_pos_ff    <= latch_full_ff ? pos_latch_ff : '0;
         rsp_latch_ff  <= latch_full_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.rpm              = rsp_rpm_ff;
   assign rsp_ch.pulse_total      = rsp_pulse_ff;
   assign rsp_ch.period_now       = rsp_period_ff;
   assign rsp_ch.latched_position = rsp_pos_ff;
   assign rsp_ch.latch_valid      = rsp_latch_ff;

`ifndef SYNTH
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIV) && div_start_ff)
      else $error("accepted request did not start the divider");

   a_done_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HOLD))
      else $error("response raised without a finished request");

   a_no_latch_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_latch_ff) |-> (rsp_pos_ff == '0))
      else $error("position reported without a capture");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tacho_period_rpm_meter_tb.sv
`default_nettype none

module tacho_period_rpm_meter_tb
   import tpm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 150;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      cmd_type     cmd;
      logic        pin_level;
      logic [31:0] motor_position;
   } tach_req_type;

   typedef struct packed {
      logic [15:0] rpm;
      logic [31:0] pulse_total;
      logic [31:0] period_now;
      logic [31:0] latched_position;
      logic        latch_valid;
   } tach_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   tpm_req_if req_ch();
   tpm_rsp_if rsp_ch();

   tacho_period_rpm_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // meter settings and state as the block should hold them
   logic [15:0] accept_min, valid_min, stale_ms, rpm_cap;
   logic [31:0] now_ms, low_at, period_ms, edge_count, pos_hold;
   logic        seen_low, have_pos;

   tach_req_type requests_todo[$];
   tach_rsp_type readings_due[$];
   tach_req_type on_wire;
   tach_rsp_type want;

   int errors = 0;
   int items_queued = 0;
   int reqs_sent = 0;
   int rsp_seen = 0;
   int settings_used = 0;
   int send_gap = 0;
   bit send_idle = 1'b1;
   int recv_wait = 0;
   bit recv_idle = 1'b1;
   int hold_left = 0;
   bit held_once = 1'b0;
   int idle_cycles = 0;

   function automatic tach_rsp_type meter_update(tach_req_type r);
      logic [31:0]  gap;
      logic [31:0]  since;
      logic [31:0]  quot;
      tach_rsp_type o;
      case (r.cmd)
         CMD_TICK: now_ms = now_ms + 1;
         CMD_PIN: begin
            if (!have_pos) begin
               pos_hold = r.motor_position;
               have_pos = 1'b1;
            end
            if (!r.pin_level) begin
               edge_count = edge_count + 1;
               if (seen_low) begin
                  gap = now_ms - low_at;
                  if (gap >= 32'(accept_min))
                     period_ms = gap;
               end
               low_at = now_ms;
               seen_low = 1'b1;
            end
         end
         CMD_CLEAR: have_pos = 1'b0;
         default: ;
      endcase
      since = now_ms - low_at;
      if (period_ms == 0 || period_ms < 32'(valid_min) || since > 32'(stale_ms)) begin
         o.rpm = '0;
      end else begin
         quot = 32'(MS_PER_MINUTE) / period_ms;
         o.rpm = (quot > 32'(rpm_cap)) ? rpm_cap : quot[15:0];
      end
      o.pulse_total      = edge_count;
      o.period_now       = period_ms;
      o.latched_position = have_pos ? pos_hold : '0;
      o.latch_valid      = have_pos;
      return o;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            readings_due.push_back(meter_update(on_wire));
            reqs_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               req_ch.valid <= 1'b0;
               send_gap--;
            end else if (requests_todo.size() != 0) begin
               on_wire = requests_todo.pop_front();
               req_ch.cmd            <= on_wire.cmd;
               req_ch.pin_level      <= on_wire.pin_level;
               req_ch.motor_position <= on_wire.motor_position;
               req_ch.valid          <= 1'b1;
               if ($urandom_range(0, 63) == 0)
                  send_idle = !send_idle;
               send_gap = send_idle ? $urandom_range(0, 7) : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (readings_due.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual rpm %0d",
                        $time, rsp_ch.rpm);
               errors++;
            end else begin
               want = readings_due.pop_front();
               check_field("rpm", 32'(want.rpm), 32'(rsp_ch.rpm));
               check_field("pulse_total", want.pulse_total, rsp_ch.pulse_total);
               check_field("period_now", want.period_now, rsp_ch.period_now);
               check_field("latched_position", want.latched_position,
                           rsp_ch.latched_position);
               check_field("latch_valid", 32'(want.latch_valid), 32'(rsp_ch.latch_valid));
            end
            if ($urandom_range(0, 63) == 0)
               recv_idle = !recv_idle;
            recv_wait = recv_idle ? $urandom_range(0, 7) : 0;
         end
         // hold off once for a long stretch so the block backs up its input
         if (!held_once && reqs_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            held_once = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (recv_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
         $display("tacho_period_rpm_meter regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_req(cmd_type c, logic pin, logic [31:0] pos);
      tach_req_type r;
      r.cmd = c;
      r.pin_level = pin;
      r.motor_position = pos;
      requests_todo.push_back(r);
      items_queued++;
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_ACCEPT: accept_min = val;
         CSR_MIN_VALID:  valid_min  = val;
         CSR_STALE:      stale_ms   = val;
         CSR_RPM_LIMIT:  rpm_cap    = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [15:0] accept, logic [15:0] valid, logic [15:0] stale,
                                logic [15:0] limit);
      write_csr(CSR_MIN_ACCEPT, accept);
      write_csr(CSR_MIN_VALID, valid);
      write_csr(CSR_STALE, stale);
      write_csr(CSR_RPM_LIMIT, limit);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // wait until every request is sent and every response is back
   task automatic drain();
      @(negedge clock);
      while (requests_todo.size() != 0 || req_ch.valid || readings_due.size() != 0)
         @(negedge clock);
   endtask

   // pulse trains with random spacing, plus clears, status reads and noise
   task automatic run_phase(logic [15:0] accept, logic [15:0] valid, logic [15:0] stale,
                            logic [15:0] limit, int count, int max_gap);
      int first;
      int k;
      load_settings(accept, valid, stale, limit);
      first = items_queued;
      while (items_queued - first < count) begin
         repeat ($urandom_range(0, max_gap))
            queue_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom);
         queue_req(CMD_PIN, 1'b1, $urandom);
         repeat ($urandom_range(0, max_gap))
            queue_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom);
         queue_req(CMD_PIN, 1'b0, $urandom);
         k = $urandom_range(0, 99);
         if (k < 10)
            queue_req(CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom);
         else if (k < 15)
            queue_req(CMD_STATUS, 1'($urandom_range(0, 1)), $urandom);
         else if (k < 22)
            queue_req(cmd_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
         else if (k < 26 && stale_ms <= 64)
            repeat (int'(stale_ms) + $urandom_range(1, 3))
               queue_req(CMD_TICK, 1'($urandom_range(0, 1)), $urandom);
      end
      drain();
   endtask

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.cmd            = CMD_STATUS;
      req_ch.pin_level      = 1'b0;
      req_ch.motor_position = '0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_MIN_ACCEPT;
      csr_wdata             = '0;
      accept_min = RST_MIN_ACCEPT;
      valid_min  = RST_MIN_VALID;
      stale_ms   = RST_STALE;
      rpm_cap    = RST_RPM_LIMIT;
      now_ms     = '0;
      low_at     = '0;
      period_ms  = '0;
      edge_count = '0;
      pos_hold   = '0;
      seen_low   = 1'b0;
      have_pos   = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: accept any period, go stale after 3 ms, no saturation
      load_settings(16'd0, 16'd1, 16'd3, 16'hffff);
      queue_req(CMD_STATUS, 1'b0, 32'h8000_0000);
      queue_req(CMD_CLEAR, 1'b1, 32'h0000_0000);
      queue_req(CMD_PIN, 1'b1, 32'h7fff_ffff);   // capture on a rising level
      queue_req(CMD_PIN, 1'b0, 32'hffff_ffff);   // first low edge, no period yet
      queue_req(CMD_PIN, 1'b0, 32'h0000_0000);   // same ms: zero period stored
      queue_req(CMD_TICK, 1'b1, 32'h0000_0000);
      queue_req(CMD_PIN, 1'b0, 32'h1234_5678);   // 1 ms period, 60000 rpm
      repeat (3) queue_req(CMD_TICK, 1'b0, 32'hffff_ffff);
      queue_req(CMD_TICK, 1'b1, 32'h0000_0001);  // one past the stale limit
      queue_req(CMD_CLEAR, 1'b0, 32'h0000_0000);
      queue_req(CMD_STATUS, 1'b1, 32'hffff_ffff);
      queue_req(CMD_PIN, 1'b1, 32'h8000_0000);
      queue_req(CMD_PIN, 1'b1, 32'h0000_0001);   // already captured: hold
      queue_req(CMD_CLEAR, 1'b1, 32'h7fff_ffff);
      queue_req(CMD_PIN, 1'b0, 32'h5555_aaaa);
      repeat (2) queue_req(CMD_TICK, 1'b0, 32'haaaa_5555);
      queue_req(CMD_PIN, 1'b0, 32'h0f0f_f0f0);
      queue_req(CMD_STATUS, 1'b0, 32'h0000_0000);
      drain();

      run_phase(RST_MIN_ACCEPT, RST_MIN_VALID, RST_STALE, RST_RPM_LIMIT, 80, 8);
      run_phase(16'd3, 16'd2, 16'd20, 16'd9999, 100, 4);
      run_phase(16'hffff, 16'hffff, 16'hffff, 16'd0, 60, 6);
      run_phase(16'd0, 16'd1, 16'd0, 16'hffff, 100, 2);
      run_phase(16'd12, 16'd8, 16'd40, 16'd5000, 110, 10);
      run_phase(16'd1, 16'd20, 16'd100, 16'd3000, 100, 12);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (readings_due.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, readings_due.size());
         errors++;
      end
      $display("Covered %0d requests over %0d register settings, %0d responses checked,",
               reqs_sent, settings_used, rsp_seen);
      $display("%0d low edges counted, one long response hold-off, %0d errors.",
               edge_count, errors);
      if (errors == 0) begin
         $display("tacho_period_rpm_meter regression: pass");
      end else begin
         $display("tacho_period_rpm_meter regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/tpm_pkg.sv
hw/rtl/tpm_if.sv
hw/rtl/tpm_div.sv
hw/rtl/tacho_period_rpm_meter.sv
tb/sv/tacho_period_rpm_meter_tb.sv
